@@ sv/bfba_pkg.sv @@
// shared types, codes and helper functions of the bitmap file block allocator
package bfba_pkg;
	localparam int CMD_W = 2;
	localparam int POS_W = 12;
	localparam int SIZE_W = 32;
	localparam int ST_W = 3;
	localparam int INO_W = 11;
	localparam int BLK_W = 12;
	localparam int CFG_W = 13;
	localparam int ILIM_W = 11;
	localparam int DLIM_W = 13;

	// bitmap word geometry
	localparam int WORD_W = 64;
	localparam int WORD_LSB = 6;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [ST_W-1:0] status_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [WORD_LSB-1:0] bitsel_t;

	localparam cmd_t CMD_MARK = 2'd0;
	localparam cmd_t CMD_ALLOC = 2'd1;
	localparam cmd_t CMD_RELEASE = 2'd2;

	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_TOO_LARGE = 3'd1;
	localparam status_t ST_NO_INODE = 3'd2;
	localparam status_t ST_NO_SPACE = 3'd3;
	localparam status_t ST_BAD_INDEX = 3'd4;

	localparam logic REG_INODE_LIMIT = 1'b0;
	localparam logic REG_DATA_LIMIT = 1'b1;

	// lowest set bit of a word
	function automatic bitsel_t first_set(input word_t v);
		bitsel_t idx;
		idx = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (v[b])
				idx = bitsel_t'(b);
		end
		return idx;
	endfunction

	// bits of word number wnum whose position lies below lim
	function automatic word_t limit_mask(input logic [31:0] lim, input logic [31:0] wnum);
		logic [31:0] base;
		word_t m;
		base = wnum << WORD_LSB;
		if (lim >= base + 32'(WORD_W))
			m = '1;
		else if (lim <= base)
			m = '0;
		else
			m = ~({WORD_W{1'b1}} << (lim - base));
		return m;
	endfunction
endpackage

@@ sv/bitmap_file_block_allocator.sv @@
// first-fit inode and data block allocator over two word-organised use bitmaps
//
//  channel   signals                                          direction  handshake
//  command   start busy command map_select bit_index size_bytes in       start & !busy
//  result    strobe status inode_number block_index last       out        strobe, one cycle
//  config    cfg_we cfg_index cfg_data                         in         cfg_we, no wait
//
// mark and release read the word, then write it back; an unused command or an index outside
// the map answers in the cycle after start. allocate first counts the blocks needed, up to
// MAX_FILE_BLOCKS, then scans the inode map word by word, then the data map word by word,
// resuming after each word that it picks blocks from, picks the chosen blocks one by one, and
// last does a read-modify-write of the data map per block; the pace is set by the single read
// port of each bitmap memory. after reset both bitmaps are cleared, one word a cycle, with busy
// high. results cannot be held off by the receiver.
module bitmap_file_block_allocator #(
	parameter int INODE_SLOTS = 1024,
	parameter int DATA_BLOCKS = 4096,
	parameter int MAX_FILE_BLOCKS = 12,
	parameter int BLOCK_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bfba_pkg::cmd_t                command,
	input  logic                          map_select,
	input  logic [bfba_pkg::POS_W-1:0]    bit_index,
	input  logic [bfba_pkg::SIZE_W-1:0]   size_bytes,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bfba_pkg::CFG_W-1:0]    cfg_data,
	output logic                          strobe,
	output bfba_pkg::status_t             status,
	output logic [bfba_pkg::INO_W-1:0]    inode_number,
	output logic [bfba_pkg::BLK_W-1:0]    block_index,
	output logic                          last
);
	import bfba_pkg::*;

	localparam int IWORDS = (INODE_SLOTS + WORD_W - 1) / WORD_W;
	localparam int DWORDS = (DATA_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int IAW = (IWORDS > 1) ? $clog2(IWORDS) : 1;
	localparam int DAW = (DWORDS > 1) ? $clog2(DWORDS) : 1;
	localparam int IPW = IAW + WORD_LSB;
	localparam int DPW = DAW + WORD_LSB;
	localparam int ILW = $clog2(INODE_SLOTS + 1);
	localparam int DLW = $clog2(DATA_BLOCKS + 1);
	localparam int CLR_WORDS = (IWORDS > DWORDS) ? IWORDS : DWORDS;
	localparam int CW = (CLR_WORDS > 1) ? $clog2(CLR_WORDS) : 1;
	localparam int NW = $clog2(MAX_FILE_BLOCKS + 1);
	localparam int PKW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
	localparam int THR_W = $clog2(MAX_FILE_BLOCKS * BLOCK_BYTES + 1);

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_MWR = 4'd2;
	localparam logic [3:0] S_NEED = 4'd3;
	localparam logic [3:0] S_ISCAN = 4'd4;
	localparam logic [3:0] S_DSCAN = 4'd5;
	localparam logic [3:0] S_DPICK = 4'd6;
	localparam logic [3:0] S_CRD = 4'd7;
	localparam logic [3:0] S_CWR = 4'd8;

	// control state
	logic [3:0] state_q;
	logic [CW-1:0] cc_q;
	logic [ILIM_W-1:0] inode_limit_q;
	logic [DLIM_W-1:0] data_limit_q;
	logic [NW-1:0] need_q;
	logic [NW-1:0] found_q;
	logic [NW-1:0] k_q;
	logic [IAW:0] ia_q;
	logic [DAW:0] da_q;
	logic iv_q;
	logic dv_q;
	logic strobe_q;

	// request and working data
	cmd_t cmd_q;
	logic sel_q;
	logic [POS_W-1:0] pos_q;
	logic [SIZE_W-1:0] size_q;
	logic [THR_W-1:0] thr_q;
	logic [IAW-1:0] ira_s1;
	logic [DAW-1:0] dra_s1;
	logic [IPW-1:0] ino_q;
	word_t iword_q;
	word_t free_q;
	logic [DAW-1:0] dw_q;
	logic [DPW-1:0] pk_q [MAX_FILE_BLOCKS];
	status_t status_q;
	logic [INO_W-1:0] ino_out_q;
	logic [BLK_W-1:0] blk_out_q;
	logic last_q;

	// bitmap memories
	word_t imem [IWORDS];
	word_t dmem [DWORDS];
	word_t i_rdata_q;
	word_t d_rdata_q;
	logic i_we;
	logic d_we;
	logic [IAW-1:0] i_wa;
	logic [IAW-1:0] i_ra;
	logic [DAW-1:0] d_wa;
	logic [DAW-1:0] d_ra;
	word_t i_wd;
	word_t d_wd;

	logic [ILW-1:0] ilim_eff;
	logic [DLW-1:0] dlim_eff;
	logic [IPW-1:0] in_ipos;
	logic [DPW-1:0] in_dpos;
	logic [IPW-1:0] ipos_q;
	logic [DPW-1:0] dpos_q;
	logic in_range;
	logic i_issue;
	logic d_issue;
	word_t i_free;
	word_t d_free;
	bitsel_t pick_bit;
	word_t pick_oh;
	logic pick_done;
	logic blk_last;
	logic mark_val;
	logic strobe_d;

	assign ilim_eff = (32'(inode_limit_q) > 32'(INODE_SLOTS)) ? ILW'(INODE_SLOTS)
		: ILW'(inode_limit_q);
	assign dlim_eff = (32'(data_limit_q) > 32'(DATA_BLOCKS)) ? DLW'(DATA_BLOCKS)
		: DLW'(data_limit_q);

	assign in_ipos = IPW'(bit_index);
	assign in_dpos = DPW'(bit_index);
	assign ipos_q = IPW'(pos_q);
	assign dpos_q = DPW'(pos_q);
	assign in_range = map_select ? (32'(bit_index) < 32'(DATA_BLOCKS))
		: (32'(bit_index) < 32'(INODE_SLOTS));
	assign mark_val = (cmd_q == CMD_MARK);

	// scan: a read goes out each cycle while the word start lies below the limit
	assign i_issue = 32'({ia_q, {WORD_LSB{1'b0}}}) < 32'(ilim_eff);
	assign d_issue = 32'({da_q, {WORD_LSB{1'b0}}}) < 32'(dlim_eff);
	assign i_free = ~i_rdata_q & limit_mask(32'(ilim_eff), 32'(ira_s1));
	assign d_free = ~d_rdata_q & limit_mask(32'(dlim_eff), 32'(dra_s1));

	assign pick_bit = first_set(free_q);
	assign pick_oh = word_t'(1) << pick_bit;
	assign pick_done = (NW'(found_q + 1'b1) == need_q);
	assign blk_last = (NW'(k_q + 1'b1) == need_q);

	// a result goes out in the cycle after each of these
	assign strobe_d = (state_q == S_IDLE) ? (start && command != CMD_ALLOC
			&& !((command == CMD_MARK || command == CMD_RELEASE) && in_range))
		: (state_q == S_MWR || state_q == S_CWR) ? 1'b1
		: (state_q == S_NEED) ? (size_q > 32'(thr_q) && need_q == NW'(MAX_FILE_BLOCKS))
		: (state_q == S_ISCAN) ? (!iv_q && !i_issue)
		: (state_q == S_DSCAN) ? (!dv_q && !d_issue)
		: 1'b0;

	always_comb begin
		i_we = 1'b0;
		d_we = 1'b0;
		i_wa = ipos_q[IPW-1:WORD_LSB];
		d_wa = dpos_q[DPW-1:WORD_LSB];
		i_wd = '0;
		d_wd = '0;
		i_ra = in_ipos[IPW-1:WORD_LSB];
		d_ra = in_dpos[DPW-1:WORD_LSB];
		unique case (state_q)
			S_CLR: begin
				i_we = (32'(cc_q) < 32'(IWORDS));
				d_we = (32'(cc_q) < 32'(DWORDS));
				i_wa = IAW'(cc_q);
				d_wa = DAW'(cc_q);
			end
			S_IDLE: begin
			end
			S_MWR: begin
				i_we = !sel_q;
				d_we = sel_q;
				i_wd = mark_val ? (i_rdata_q | (word_t'(1) << ipos_q[WORD_LSB-1:0]))
					: (i_rdata_q & ~(word_t'(1) << ipos_q[WORD_LSB-1:0]));
				d_wd = mark_val ? (d_rdata_q | (word_t'(1) << dpos_q[WORD_LSB-1:0]))
					: (d_rdata_q & ~(word_t'(1) << dpos_q[WORD_LSB-1:0]));
			end
			S_NEED: begin
			end
			S_ISCAN: begin
				i_ra = ia_q[IAW-1:0];
			end
			S_DSCAN: begin
				d_ra = da_q[DAW-1:0];
			end
			S_DPICK: begin
			end
			S_CRD: begin
				d_ra = pk_q[0][DPW-1:WORD_LSB];
				// inode word was kept from the scan, so it is written without a read
				i_we = (k_q == '0);
				i_wa = ino_q[IPW-1:WORD_LSB];
				i_wd = iword_q | (word_t'(1) << ino_q[WORD_LSB-1:0]);
			end
			S_CWR: begin
				d_we = 1'b1;
				d_wa = pk_q[0][DPW-1:WORD_LSB];
				d_wd = d_rdata_q | (word_t'(1) << pk_q[0][WORD_LSB-1:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (i_we)
			imem[i_wa] <= i_wd;
		i_rdata_q <= imem[i_ra];
	end

	always_ff @(posedge clk) begin
		if (d_we)
			dmem[d_wa] <= d_wd;
		d_rdata_q <= dmem[d_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cc_q <= '0;
			inode_limit_q <= ILIM_W'(1024);
			data_limit_q <= DLIM_W'(4096);
			need_q <= NW'(1);
			found_q <= '0;
			k_q <= '0;
			ia_q <= '0;
			da_q <= '0;
			iv_q <= 1'b0;
			dv_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INODE_LIMIT: inode_limit_q <= cfg_data[ILIM_W-1:0];
					REG_DATA_LIMIT: data_limit_q <= cfg_data[DLIM_W-1:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_CLR: begin
					cc_q <= cc_q + 1'b1;
					if (cc_q == CW'(CLR_WORDS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						found_q <= '0;
						need_q <= NW'(1);
						if ((command == CMD_MARK || command == CMD_RELEASE) && in_range)
							state_q <= S_MWR;
						else if (command == CMD_ALLOC)
							state_q <= S_NEED;
					end
				end
				S_MWR: begin
					state_q <= S_IDLE;
				end
				S_NEED: begin
					if (size_q <= 32'(thr_q)) begin
						state_q <= S_ISCAN;
						ia_q <= '0;
						iv_q <= 1'b0;
					end else if (need_q == NW'(MAX_FILE_BLOCKS)) begin
						state_q <= S_IDLE;
					end else begin
						need_q <= need_q + 1'b1;
					end
				end
				S_ISCAN: begin
					iv_q <= i_issue;
					if (i_issue)
						ia_q <= ia_q + 1'b1;
					if (iv_q && i_free != '0) begin
						state_q <= S_DSCAN;
						da_q <= '0;
						dv_q <= 1'b0;
					end else if (!iv_q && !i_issue) begin
						state_q <= S_IDLE;
					end
				end
				S_DSCAN: begin
					if (dv_q && d_free != '0) begin
						// drop the read in flight, resume after this word
						state_q <= S_DPICK;
						dv_q <= 1'b0;
						da_q <= {1'b0, dra_s1} + 1'b1;
					end else begin
						dv_q <= d_issue;
						if (d_issue)
							da_q <= da_q + 1'b1;
						if (!dv_q && !d_issue)
							state_q <= S_IDLE;
					end
				end
				S_DPICK: begin
					found_q <= found_q + 1'b1;
					if (pick_done) begin
						state_q <= S_CRD;
						k_q <= '0;
					end else if ((free_q & ~pick_oh) == '0) begin
						state_q <= S_DSCAN;
					end
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					if (blk_last) begin
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= command;
				sel_q <= map_select;
				pos_q <= bit_index;
				size_q <= size_bytes;
				thr_q <= THR_W'(BLOCK_BYTES);
				status_q <= ST_BAD_INDEX;
				ino_out_q <= '0;
				blk_out_q <= '0;
				last_q <= 1'b1;
			end
			S_MWR: begin
				status_q <= ST_OK;
				ino_out_q <= '0;
				blk_out_q <= '0;
				last_q <= 1'b1;
			end
			S_NEED: begin
				thr_q <= thr_q + THR_W'(BLOCK_BYTES);
				status_q <= ST_TOO_LARGE;
				ino_out_q <= '0;
				blk_out_q <= '0;
				last_q <= 1'b1;
			end
			S_ISCAN: begin
				ira_s1 <= ia_q[IAW-1:0];
				if (iv_q && i_free != '0) begin
					ino_q <= {ira_s1, first_set(i_free)};
					iword_q <= i_rdata_q;
				end
				status_q <= ST_NO_INODE;
				ino_out_q <= '0;
				blk_out_q <= '0;
				last_q <= 1'b1;
			end
			S_DSCAN: begin
				dra_s1 <= da_q[DAW-1:0];
				if (dv_q && d_free != '0) begin
					free_q <= d_free;
					dw_q <= dra_s1;
				end
				status_q <= ST_NO_SPACE;
				ino_out_q <= '0;
				blk_out_q <= '0;
				last_q <= 1'b1;
			end
			S_DPICK: begin
				pk_q[found_q[PKW-1:0]] <= {dw_q, pick_bit};
				free_q <= free_q & ~pick_oh;
			end
			S_CWR: begin
				status_q <= ST_OK;
				ino_out_q <= INO_W'({1'b0, ino_q} + 1'b1);
				blk_out_q <= BLK_W'(pk_q[0]);
				last_q <= blk_last;
				// the block list drains from the head
				for (int j = 0; j < MAX_FILE_BLOCKS - 1; j++)
					pk_q[j] <= pk_q[j+1];
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign status = status_q;
	assign inode_number = ino_out_q;
	assign block_index = blk_out_q;
	assign last = last_q;

	// results of one allocation never come in adjacent cycles
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> !strobe)
		else $error("results of one request not spaced");

	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_OK |-> last)
		else $error("failure result not final");

	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= need_q)
		else $error("more blocks chosen than needed");

	a_inode_write: assert property (@(posedge clk) disable iff (!arst_n)
		i_we |-> (state_q == S_CLR || state_q == S_MWR || state_q == S_CRD))
		else $error("inode map written outside update states");
endmodule
